FILE: sv/dfrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfrv_pkg
// Shared types and codes for the defer record validator.
// ----------------------------------------------------------------------------
package dfrv_pkg;

   localparam int CNT_W = 7;   // holds a slot run length up to 127

   typedef enum logic [1:0] {
      KIND_SLOT      = 2'd0,
      KIND_ACCEPT    = 2'd1,
      KIND_REJECT    = 2'd2,
      KIND_UNBOUNDED = 2'd3
   } kind_type;

   localparam logic [1:0] LAYOUT_CONTIG = 2'd0;
   localparam logic [1:0] LAYOUT_LEGACY = 2'd2;

   localparam logic [1:0] CSR_LAYOUT    = 2'd0;
   localparam logic [1:0] CSR_PTR_LOG   = 2'd1;
   localparam logic [1:0] CSR_MAX_FRAME = 2'd2;

   typedef struct packed {
      logic [1:0]  layout;
      logic [1:0]  ptr_log;
      logic [31:0] max_frame;
   } cfg_type;

   // One queued command: optional reject of an abandoned record, then a run
   // of cnt slots (base, base-step, ...), then an optional main result.
   typedef struct packed {
      logic             pre_rej;
      logic [CNT_W-1:0] cnt;
      logic [31:0]      base;
      logic [3:0]       step;
      logic             has_main;
      kind_type         kind;
      logic [31:0]      value;
      logic [31:0]      dbo;
      logic             last;
   } cmd_type;

endpackage
`default_nettype wire

FILE: sv/dfrv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfrv_front
// Varint decoder and record parser; issues at most one command per byte.
// ----------------------------------------------------------------------------
module dfrv_front #(
   parameter int MAX_SLOTS = 8,
   parameter int MAX_ARGS  = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   record_start,
   input  logic signed [31:0]     frame_size,
   input  dfrv_pkg::cfg_type      cfg,
   output logic                   push,
   output dfrv_pkg::cmd_type      cmd
);

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_MAXARG = 8'b0000_0010,
      PH_BITS   = 8'b0000_0100,
      PH_SECOND = 8'b0000_1000,
      PH_WIDTH  = 8'b0001_0000,
      PH_SLOT   = 8'b0010_0000,
      PH_COUNT  = 8'b0100_0000,
      PH_SKIP   = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  shift_ff, shift_in;
   logic [31:0] bound_ff, bound_in;
   logic [31:0] maxarg_ff, maxarg_in;
   logic [31:0] bmo_ff, bmo_in;
   logic [6:0]  dl_ff, dl_in;
   logic [7:0]  skip_ff, skip_in;
   logic [31:0] first_ff, first_in;

   // A slot-kind main result is genuine only when the parser stayed in PH_SLOT
   // handling (next phase is COUNT, or a defer ended); anything else is a reject.
   function automatic logic slot_ok_kind(input phase_type ph, input logic f,
                                         input logic [31:0] val);
      slot_ok_kind = (ph == PH_COUNT || f) && (val != 32'd0);
   endfunction

   always_comb begin
      logic        legacy;
      logic        fin;
      logic        go;
      logic [3:0]  step;
      logic [31:0] v;
      logic [31:0] run;
      logic [31:0] nb;
      logic [6:0]  chunk;
      logic        slot_ok;

      legacy = (cfg.layout == dfrv_pkg::LAYOUT_LEGACY);
      step   = 4'(4'd1 << cfg.ptr_log);
      chunk  = data_byte[6:0];
      fin    = 1'b0;
      go     = 1'b0;
      v      = 32'd0;
      run    = 32'd0;
      slot_ok = 1'b0;
      nb = (frame_size != 32'sd0 && !frame_size[31] && unsigned'(frame_size) < cfg.max_frame)
           ? unsigned'(frame_size) : cfg.max_frame;

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      shift_in  = shift_ff;
      bound_in  = bound_ff;
      maxarg_in = maxarg_ff;
      bmo_in    = bmo_ff;
      dl_in     = dl_ff;
      skip_in   = skip_ff;
      first_in  = first_ff;
      cmd       = '0;
      cmd.kind  = dfrv_pkg::KIND_SLOT;

      if (accept && record_start) begin
         cmd.pre_rej = (phase_ff != PH_IDLE);
         phase_in  = legacy ? PH_MAXARG : PH_BITS;
         acc_in    = 32'd0;
         shift_in  = 3'd0;
         bound_in  = nb;
         maxarg_in = 32'd0;
         bmo_in    = 32'd0;
         dl_in     = 7'd0;
         skip_in   = 8'd0;
         first_in  = 32'd0;
      end

      if (accept && phase_in != PH_IDLE) begin
         if (shift_in >= 3'd4) begin
            if (data_byte[7] || chunk > 7'd15) begin
               acc_in   = 32'd0;
               shift_in = 3'd0;
               cmd.has_main = 1'b1;
               cmd.kind     = dfrv_pkg::KIND_REJECT;
               cmd.last     = 1'b1;
               phase_in     = PH_IDLE;
            end else begin
               acc_in = acc_in | {chunk[3:0], 28'd0};
               go = 1'b1;
            end
         end else begin
            case (shift_in[1:0])
               2'd0:    acc_in = acc_in | {25'd0, chunk};
               2'd1:    acc_in = acc_in | {18'd0, chunk, 7'd0};
               2'd2:    acc_in = acc_in | {11'd0, chunk, 14'd0};
               default: acc_in = acc_in | {4'd0, chunk, 21'd0};
            endcase
            go = 1'b1;
         end

         if (go && data_byte[7]) begin
            shift_in = shift_in + 3'd1;
         end else if (go) begin
            v        = acc_in;
            acc_in   = 32'd0;
            shift_in = 3'd0;
            slot_ok  = (v != 32'd0) && ((v[2:0] & (step[2:0] - 3'd1)) == 3'd0) && (v < bmo_in);
            run      = v >> cfg.ptr_log;
            unique case (phase_in)
               PH_MAXARG: begin
                  if (v >= bound_in) cmd.has_main = 1'b1;
                  else begin
                     maxarg_in = v;
                     phase_in  = PH_BITS;
                  end
               end
               PH_BITS: begin
                  if (v == 32'd0 || v >= bound_in) cmd.has_main = 1'b1;
                  else begin
                     bmo_in   = v;
                     phase_in = PH_SECOND;
                  end
               end
               PH_SECOND: begin
                  if (cfg.layout == dfrv_pkg::LAYOUT_CONTIG) begin
                     if (!slot_ok) cmd.has_main = 1'b1;
                     else begin
                        first_in     = v;
                        cmd.has_main = 1'b1;
                        cmd.value    = v;
                        cmd.dbo      = bmo_in;
                        cmd.last     = 1'b1;
                        phase_in     = PH_IDLE;
                        if (run > 32'(MAX_SLOTS)) begin
                           cmd.kind = dfrv_pkg::KIND_UNBOUNDED;
                        end else begin
                           cmd.kind = dfrv_pkg::KIND_ACCEPT;
                           cmd.cnt  = run[dfrv_pkg::CNT_W-1:0];
                           cmd.base = v;
                           cmd.step = step;
                        end
                     end
                  end else if (v == 32'd0 || v > 32'(MAX_SLOTS)) begin
                     cmd.has_main = 1'b1;
                  end else begin
                     dl_in    = v[6:0];
                     phase_in = legacy ? PH_WIDTH : PH_SLOT;
                  end
               end
               PH_WIDTH: begin
                  if (v > maxarg_in) cmd.has_main = 1'b1;
                  else phase_in = PH_SLOT;
               end
               PH_SLOT: begin
                  if (!slot_ok) cmd.has_main = 1'b1;
                  else begin
                     if (first_in == 32'd0) first_in = v;
                     cmd.has_main = 1'b1;
                     cmd.kind     = dfrv_pkg::KIND_SLOT;
                     cmd.value    = v;
                     cmd.dbo      = bmo_in;
                     if (legacy) phase_in = PH_COUNT;
                     else fin = 1'b1;
                  end
               end
               PH_COUNT: begin
                  if (v > 32'(MAX_ARGS)) cmd.has_main = 1'b1;
                  else begin
                     skip_in = 8'(v[7:0] * 8'd3);
                     if (skip_in == 8'd0) fin = 1'b1;
                     else phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  if (v >= bound_in) cmd.has_main = 1'b1;
                  else begin
                     skip_in = skip_in - 8'd1;
                     if (skip_in == 8'd0) fin = 1'b1;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase

            // a main result set with no kind of its own here is a reject
            if (cmd.has_main && cmd.kind == dfrv_pkg::KIND_SLOT && !slot_ok_kind(phase_in, fin, cmd.value)) begin
               cmd.kind  = dfrv_pkg::KIND_REJECT;
               cmd.value = 32'd0;
               cmd.dbo   = 32'd0;
               cmd.last  = 1'b1;
               phase_in  = PH_IDLE;
            end

            if (fin) begin
               dl_in = dl_in - 7'd1;
               if (dl_in == 7'd0) begin
                  if (cmd.has_main) begin
                     cmd.cnt  = dfrv_pkg::CNT_W'(1);
                     cmd.base = cmd.value;
                  end
                  cmd.has_main = 1'b1;
                  cmd.kind     = dfrv_pkg::KIND_ACCEPT;
                  cmd.value    = first_in;
                  cmd.dbo      = bmo_in;
                  cmd.last     = 1'b1;
                  phase_in     = PH_IDLE;
               end else begin
                  phase_in = legacy ? PH_WIDTH : PH_SLOT;
               end
            end
         end
      end
      push = accept && (cmd.pre_rej || cmd.has_main);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         acc_ff    <= 32'd0;
         shift_ff  <= 3'd0;
         bound_ff  <= 32'd0;
         maxarg_ff <= 32'd0;
         bmo_ff    <= 32'd0;
         dl_ff     <= 7'd0;
         skip_ff   <= 8'd0;
         first_ff  <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         shift_ff  <= shift_in;
         bound_ff  <= bound_in;
         maxarg_ff <= maxarg_in;
         bmo_ff    <= bmo_in;
         dl_ff     <= dl_in;
         skip_ff   <= skip_in;
         first_ff  <= first_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/dfrv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfrv_queue
// Small command FIFO between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module dfrv_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dfrv_pkg::cmd_type wr_cmd,
   input  logic              pop,
   output dfrv_pkg::cmd_type head,
   output logic              head_valid,
   output logic              full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   dfrv_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? ((wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? ((rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   assign head       = entry_ff[rp_ff];
   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == CW'(DEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/dfrv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfrv_back
// Expands queued commands into result transactions, one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module dfrv_back (
   input  logic              clock,
   input  logic              reset,
   input  dfrv_pkg::cmd_type head,
   input  logic              head_valid,
   output logic              pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic [31:0]       rsp_value,
   output logic [31:0]       rsp_defer_bits_offset,
   output logic              rsp_last
);

   logic                       valid_ff, valid_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [31:0]                value_ff, value_in;
   logic [31:0]                dbo_ff, dbo_in;
   logic                       last_ff, last_in;
   logic                       pre_done_ff, pre_done_in;
   logic [dfrv_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [31:0]                off_ff, off_in;
   logic                       load;

   always_comb begin
      load        = head_valid && (!valid_ff || !rsp_stall);
      valid_in    = load ? 1'b1 : (valid_ff && rsp_stall);
      kind_in     = kind_ff;
      value_in    = value_ff;
      dbo_in      = dbo_ff;
      last_in     = last_ff;
      pre_done_in = pre_done_ff;
      idx_in      = idx_ff;
      off_in      = off_ff;
      pop         = 1'b0;
      if (load) begin
         if (head.pre_rej && !pre_done_ff) begin
            kind_in  = dfrv_pkg::KIND_REJECT;
            value_in = 32'd0;
            dbo_in   = 32'd0;
            last_in  = 1'b1;
            if (head.cnt == '0 && !head.has_main) pop = 1'b1;
            else pre_done_in = 1'b1;
         end else if (idx_ff < head.cnt) begin
            kind_in  = dfrv_pkg::KIND_SLOT;
            value_in = head.base - off_ff;
            dbo_in   = head.dbo;
            last_in  = 1'b0;
            idx_in   = idx_ff + 1'b1;
            off_in   = off_ff + 32'(head.step);
         end else begin
            kind_in  = head.kind;
            value_in = head.value;
            dbo_in   = head.dbo;
            last_in  = head.last;
            pop      = 1'b1;
         end
         if (pop) begin
            pre_done_in = 1'b0;
            idx_in      = '0;
            off_in      = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pre_done_ff <= 1'b0;
         idx_ff      <= '0;
         off_ff      <= 32'd0;
      end else begin
         valid_ff    <= valid_in;
         pre_done_ff <= pre_done_in;
         idx_ff      <= idx_in;
         off_ff      <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      dbo_ff   <= dbo_in;
      last_ff  <= last_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_value             = value_ff;
   assign rsp_defer_bits_offset = dbo_ff;
   assign rsp_last              = last_ff;

endmodule
`default_nettype wire

FILE: sv/defer_record_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// defer_record_validator
// Byte-serial parser and checker for defer records, emitting slot offsets
// and a final status per record.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | data_byte, record_start, frame_size
//  rsp     | out       | rsp_valid/rsp_stall | kind, value, defer_bits_offset, last
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
//  The parser takes one byte per cycle while req_stall is low and queues at most one command per byte.
//  The sequencer issues one result per cycle while rsp_stall is low; a contiguous run of n
//  slots occupies it for n slot results and the status, during which the command queue absorbs bytes.
//  req_stall rises only when the QUEUE_DEPTH-entry queue is full.
//  Reset is synchronous; it clears the parser, queue and output valid.
// ----------------------------------------------------------------------------
module defer_record_validator #(
   parameter int MAX_SLOTS   = 8,
   parameter int MAX_ARGS    = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_record_start,
   input  logic signed [31:0] req_frame_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [31:0]        rsp_value,
   output logic [31:0]        rsp_defer_bits_offset,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   dfrv_pkg::cfg_type cfg_ff, cfg_in;
   dfrv_pkg::cmd_type cmd, head;
   logic              accept, push, pop, head_valid, q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dfrv_pkg::CSR_LAYOUT:    cfg_in.layout    = csr_wdata[1:0];
            dfrv_pkg::CSR_PTR_LOG:   cfg_in.ptr_log   = csr_wdata[1:0];
            dfrv_pkg::CSR_MAX_FRAME: cfg_in.max_frame = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout    <= dfrv_pkg::LAYOUT_CONTIG;
         cfg_ff.ptr_log   <= 2'd3;
         cfg_ff.max_frame <= 32'd1048576;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   dfrv_front #(.MAX_SLOTS(MAX_SLOTS), .MAX_ARGS(MAX_ARGS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .record_start (req_record_start),
      .frame_size   (req_frame_size),
      .cfg          (cfg_ff),
      .push         (push),
      .cmd          (cmd)
   );

   dfrv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .wr_cmd     (cmd),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   dfrv_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head),
      .head_valid            (head_valid),
      .pop                   (pop),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_kind              (rsp_kind),
      .rsp_value             (rsp_value),
      .rsp_defer_bits_offset (rsp_defer_bits_offset),
      .rsp_last              (rsp_last)
   );

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full) else $error("command pushed into full queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != dfrv_pkg::KIND_SLOT)))
      else $error("last flag disagrees with result kind");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

FILE: tb/record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_checker
// Watches the request, response and register ports of the defer record
// validator, keeps a cycle-free copy of its parser and compares every
// response transaction against the oldest predicted one.
// ----------------------------------------------------------------------------
module record_checker #(
   parameter int MAX_SLOTS = 8,
   parameter int MAX_ARGS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_record_start,
   input  logic [31:0] req_frame_size,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_value,
   input  logic [31:0] rsp_defer_bits_offset,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef enum logic [3:0] {
      P_IDLE, P_MAXARG, P_BITS, P_SECOND, P_WIDTH, P_SLOT, P_COUNT, P_SKIP
   } parse_phase_type;

   typedef struct {
      dfrv_pkg::kind_type kind;
      logic [31:0]        value;
      logic [31:0]        dbo;
      logic               last;
   } outcome_type;

   outcome_type outcomes[$];

   logic [1:0]      cfg_layout;
   logic [1:0]      cfg_ptr_log;
   logic [31:0]     cfg_max_frame;
   parse_phase_type phase;
   logic [31:0]     acc;
   logic [2:0]      acc_bytes;
   logic [31:0]     bound;
   logic [31:0]     max_arg;
   logic [31:0]     bits_off;
   logic [6:0]      defers_left;
   logic [7:0]      words_left;
   logic [31:0]     first_slot;

   assign pending = outcomes.size();

   function automatic bit is_legacy();
      return cfg_layout == dfrv_pkg::LAYOUT_LEGACY;
   endfunction

   function automatic bit slot_ok(logic [31:0] v);
      logic [31:0] mask;
      mask = (32'd1 << cfg_ptr_log) - 32'd1;
      return v != 0 && (v & mask) == 0 && v < bits_off;
   endfunction

   task automatic push(dfrv_pkg::kind_type k, logic [31:0] v, logic [31:0] d, logic l);
      outcome_type o;
      o.kind = k;
      o.value = v;
      o.dbo = d;
      o.last = l;
      outcomes = {outcomes, o};
   endtask

   task automatic reject_record();
      push(dfrv_pkg::KIND_REJECT, 32'd0, 32'd0, 1'b1);
      phase = P_IDLE;
   endtask

   task automatic finish_defer();
      defers_left = defers_left - 7'd1;
      if (defers_left == 0) begin
         push(dfrv_pkg::KIND_ACCEPT, first_slot, bits_off, 1'b1);
         phase = P_IDLE;
      end else begin
         phase = is_legacy() ? P_WIDTH : P_SLOT;
      end
   endtask

   task automatic take_value(logic [31:0] v);
      logic [31:0] step;
      logic [31:0] run;
      step = 32'd1 << cfg_ptr_log;
      case (phase)
         P_MAXARG: begin
            if (v >= bound) reject_record();
            else begin
               max_arg = v;
               phase = P_BITS;
            end
         end
         P_BITS: begin
            if (v == 0 || v >= bound) reject_record();
            else begin
               bits_off = v;
               phase = P_SECOND;
            end
         end
         P_SECOND: begin
            if (cfg_layout == dfrv_pkg::LAYOUT_CONTIG) begin
               if (!slot_ok(v)) reject_record();
               else begin
                  first_slot = v;
                  run = v >> cfg_ptr_log;
                  if (run > MAX_SLOTS) begin
                     push(dfrv_pkg::KIND_UNBOUNDED, v, bits_off, 1'b1);
                  end else begin
                     for (int i = 0; i < run; i++)
                        push(dfrv_pkg::KIND_SLOT, v - i * step, bits_off, 1'b0);
                     push(dfrv_pkg::KIND_ACCEPT, v, bits_off, 1'b1);
                  end
                  phase = P_IDLE;
               end
            end else if (v == 0 || v > MAX_SLOTS) begin
               reject_record();
            end else begin
               defers_left = v[6:0];
               phase = is_legacy() ? P_WIDTH : P_SLOT;
            end
         end
         P_WIDTH: begin
            if (v > max_arg) reject_record();
            else phase = P_SLOT;
         end
         P_SLOT: begin
            if (!slot_ok(v)) reject_record();
            else begin
               if (first_slot == 0) first_slot = v;
               push(dfrv_pkg::KIND_SLOT, v, bits_off, 1'b0);
               if (is_legacy()) phase = P_COUNT;
               else finish_defer();
            end
         end
         P_COUNT: begin
            if (v > MAX_ARGS) reject_record();
            else begin
               words_left = 8'(v * 3);
               if (words_left == 0) finish_defer();
               else phase = P_SKIP;
            end
         end
         P_SKIP: begin
            if (v >= bound) reject_record();
            else begin
               words_left = words_left - 8'd1;
               if (words_left == 0) finish_defer();
            end
         end
         default: phase = P_IDLE;
      endcase
   endtask

   task automatic take_byte(logic [7:0] b, logic start, logic [31:0] fs);
      logic [6:0]  chunk;
      logic [31:0] v;
      if (start) begin
         if (phase != P_IDLE) reject_record();
         if (fs != 0 && !fs[31] && fs < cfg_max_frame) bound = fs;
         else bound = cfg_max_frame;
         phase = is_legacy() ? P_MAXARG : P_BITS;
         acc = 0;
         acc_bytes = 0;
         max_arg = 0;
         bits_off = 0;
         defers_left = 0;
         words_left = 0;
         first_slot = 0;
      end
      if (phase == P_IDLE) return;
      chunk = b[6:0];
      if (acc_bytes >= 4) begin
         // fifth byte may carry only the top four bits and must end the varint
         if (b[7] || chunk > 15) begin
            acc = 0;
            acc_bytes = 0;
            reject_record();
            return;
         end
         acc = acc | (32'(chunk) << 28);
      end else begin
         acc = acc | (32'(chunk) << (7 * acc_bytes));
      end
      if (b[7]) begin
         acc_bytes = acc_bytes + 3'd1;
         return;
      end
      v = acc;
      acc = 0;
      acc_bytes = 0;
      take_value(v);
   endtask

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         cfg_layout = 2'd0;
         cfg_ptr_log = 2'd3;
         cfg_max_frame = 32'd1048576;
         phase = P_IDLE;
         acc = 0;
         acc_bytes = 0;
         bound = 0;
         max_arg = 0;
         bits_off = 0;
         defers_left = 0;
         words_left = 0;
         first_slot = 0;
         outcomes.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcomes.size() == 0) begin
               $error("unexpected response transaction kind=%0d value=%h",
                      rsp_kind, rsp_value);
               fail_count++;
            end else begin
               o = outcomes.pop_front();
               if (rsp_kind !== o.kind) begin
                  $error("kind: expected %0d, actual %0d", o.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_value !== o.value) begin
                  $error("value: expected %h, actual %h", o.value, rsp_value);
                  fail_count++;
               end
               if (rsp_defer_bits_offset !== o.dbo) begin
                  $error("defer_bits_offset: expected %h, actual %h",
                         o.dbo, rsp_defer_bits_offset);
                  fail_count++;
               end
               if (rsp_last !== o.last) begin
                  $error("last: expected %0b, actual %0b", o.last, rsp_last);
                  fail_count++;
               end
            end
         end
         // a register write applies from the next transaction on
         if (req_valid && !req_stall)
            take_byte(req_data_byte, req_record_start, req_frame_size);
         if (csr_we) begin
            case (csr_index)
               dfrv_pkg::CSR_LAYOUT:    cfg_layout = csr_wdata[1:0];
               dfrv_pkg::CSR_PTR_LOG:   cfg_ptr_log = csr_wdata[1:0];
               dfrv_pkg::CSR_MAX_FRAME: cfg_max_frame = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the defer record validator: well-formed and broken records
// in all layouts and pointer sizes, varint edge cases, random flow control.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUIET_CYCLES = 40;
   localparam int WATCHDOG     = 20000;
   localparam int MAX_ARGS_TB  = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_record_start = 1'b0;
   logic signed [31:0] req_frame_size = 32'sd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_value;
   logic [31:0] rsp_defer_bits_offset;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_wdata = 32'd0;

   int fail_count;
   int pending;
   int tx_pct;
   int rx_pct;
   int byte_count;
   int quiet = 0;

   // test-side view of the registers, used to shape records
   logic [1:0]  cur_layout;
   logic [1:0]  cur_ptr_log;
   logic [31:0] cur_max_frame;

   // first byte of the next record carries the start flag and frame size
   bit          start_due;
   logic [31:0] start_fs;

   defer_record_validator i_dut (.*);

   record_checker i_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < rx_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_record_start <= start_due;
      req_frame_size <= start_due ? start_fs : 32'($urandom);
      start_due = 0;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] v);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         dfrv_pkg::CSR_LAYOUT:    cur_layout = v[1:0];
         dfrv_pkg::CSR_PTR_LOG:   cur_ptr_log = v[1:0];
         dfrv_pkg::CSR_MAX_FRAME: cur_max_frame = v;
         default: ;
      endcase
   endtask

   // LEB128, optionally padded with redundant continuation bytes
   task automatic put_varint(logic [31:0] v, bit pad);
      int n;
      int total;
      logic [7:0] b;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 0) n++;
      total = pad ? $urandom_range(n, 5) : n;
      for (int i = 0; i < total; i++) begin
         b = 8'((v >> (7 * i)) & 32'h7f);
         if (i < total - 1) b[7] = 1'b1;
         send_byte(b);
      end
   endtask

   task automatic begin_record(logic [31:0] fs);
      start_due = 1;
      start_fs = fs;
   endtask

   task automatic send_values(logic [31:0] vals[$]);
      foreach (vals[i]) put_varint(vals[i], $urandom_range(9) == 0);
   endtask

   function automatic logic [31:0] pick_fs();
      case ($urandom_range(3))
         0: return 32'($urandom_range(64, 4096));
         1: return 32'($urandom);
         2: return 32'd0;
         default: return 32'($urandom_range(8, 200));
      endcase
   endfunction

   // builds one record for the current layout; bad ones get a mutation
   task automatic random_record(bit bad);
      logic [31:0] vals[$];
      logic [31:0] fs;
      logic [31:0] bnd;
      logic [31:0] bits;
      logic [31:0] ps;
      logic [31:0] slot;
      logic [31:0] marg;
      logic [31:0] w_val;
      int cnt;
      int argc;
      int pos;
      fs = pick_fs();
      bnd = (fs != 0 && !fs[31] && fs < cur_max_frame) ? fs : cur_max_frame;
      ps = 32'd1 << cur_ptr_log;
      if (bnd - 1 > 4096) bits = $urandom_range(ps * 12, 4096);
      else bits = bnd - 1;
      marg = $urandom_range(0, 64);
      if (cur_layout == dfrv_pkg::LAYOUT_LEGACY) vals = {vals, marg};
      vals = {vals, bits};
      if (cur_layout == dfrv_pkg::LAYOUT_CONTIG) begin
         slot = ps * $urandom_range(1, 12);
         if (slot >= bits) slot = ps;
         vals = {vals, slot};
      end else begin
         cnt = ($urandom_range(7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
         vals = {vals, 32'(cnt)};
         for (int d = 0; d < cnt; d++) begin
            if (cur_layout == dfrv_pkg::LAYOUT_LEGACY) begin
               w_val = $urandom_range(0, marg);
               vals = {vals, w_val};
            end
            slot = ps * $urandom_range(1, 12);
            if (slot >= bits) slot = ps;
            vals = {vals, slot};
            if (cur_layout == dfrv_pkg::LAYOUT_LEGACY) begin
               argc = ($urandom_range(30) == 0) ? MAX_ARGS_TB : $urandom_range(0, 2);
               vals = {vals, 32'(argc)};
               for (int w = 0; w < argc * 3; w++) begin
                  w_val = $urandom_range(0, (bnd > 300) ? 300 : bnd - 1);
                  vals = {vals, w_val};
               end
            end
         end
      end
      if (bad) begin
         pos = $urandom_range(0, vals.size() - 1);
         case ($urandom_range(3))
            0: vals[pos] = $urandom;
            1: vals[pos] = $urandom_range(0, 100);
            2: vals[pos] = vals[pos] + 1;
            default: while (vals.size() > pos) void'(vals.pop_back());
         endcase
      end
      begin_record(fs);
      send_values(vals);
      if (bad && $urandom_range(3) == 0) send_byte(8'($urandom));
   endtask

   task automatic random_config();
      write_reg(dfrv_pkg::CSR_LAYOUT, 32'($urandom_range(0, 3)));
      write_reg(dfrv_pkg::CSR_PTR_LOG, ($urandom_range(4) == 0) ? 32'($urandom_range(0, 1))
                                                                : 32'($urandom_range(2, 3)));
      case ($urandom_range(4))
         0: write_reg(dfrv_pkg::CSR_MAX_FRAME, 32'hffff_ffff);
         1: write_reg(dfrv_pkg::CSR_MAX_FRAME, 32'd1);
         2: write_reg(dfrv_pkg::CSR_MAX_FRAME, 32'($urandom));
         default: write_reg(dfrv_pkg::CSR_MAX_FRAME, 32'($urandom_range(100, 5000)));
      endcase
   endtask

   initial begin
      int rand_bytes;
      tx_pct = 0;
      rx_pct = 0;
      byte_count = 0;
      start_due = 0;
      cur_layout = 2'd0;
      cur_ptr_log = 2'd3;
      cur_max_frame = 32'd1048576;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: contiguous runs at reset settings
      begin_record(32'd4096); send_values({32'd200, 32'd64});   // eight slots
      begin_record(32'd4096); send_values({32'd200, 32'd72});   // unbounded
      begin_record(32'h7fff_ffff); send_values({32'd16, 32'd8});
      begin_record(32'h8000_0000); send_values({32'd16, 32'd12}); // misaligned
      begin_record(32'd0); send_values({32'd0});                // zero bitmask
      // largest varint, five bytes, over the bound
      begin_record(32'd100); put_varint(32'hffff_ffff, 0);
      // fifth byte too big, then six-byte varint
      begin_record(32'd100);
      send_byte(8'h80); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
      send_byte(8'h10);
      begin_record(32'd100);
      send_byte(8'hff); send_byte(8'hff); send_byte(8'hff); send_byte(8'hff);
      send_byte(8'h8f);
      // idle bytes, then a start abandoning an open record
      send_byte(8'h05); send_byte(8'hff);
      begin_record(32'd100); send_byte(8'h90);
      begin_record(32'd100); put_varint(32'd40, 1); put_varint(32'd8, 1);

      write_reg(dfrv_pkg::CSR_LAYOUT, 32'd1);
      begin_record(32'd500); send_values({32'd400, 32'd2, 32'd16, 32'd8});
      begin_record(32'd500); send_values({32'd400, 32'd9});
      write_reg(dfrv_pkg::CSR_LAYOUT, 32'd2);
      write_reg(dfrv_pkg::CSR_PTR_LOG, 32'd2);
      begin_record(32'd500);
      send_values({32'd10, 32'd400, 32'd1, 32'd10, 32'd12, 32'd1,
                   32'd1, 32'd2, 32'd3});
      begin_record(32'd500); send_values({32'd10, 32'd400, 32'd1, 32'd11});
      write_reg(dfrv_pkg::CSR_LAYOUT, 32'd3);
      begin_record(32'd500); send_values({32'd400, 32'd1, 32'd4});
      write_reg(2'd3, 32'($urandom));
      write_reg(dfrv_pkg::CSR_MAX_FRAME, 32'd1);
      begin_record(32'd0); send_values({32'd1});

      // random phase
      rand_bytes = 0;
      while (rand_bytes < 330) begin
         if (rand_bytes < 110) begin tx_pct = 30; rx_pct = 54; end
         else if (rand_bytes < 220) begin tx_pct = 54; rx_pct = 30; end
         else begin tx_pct = 0; rx_pct = 0; end
         random_config();
         for (int r = 0; r < 6; r++) begin
            byte_count = 0;
            if ($urandom_range(9) == 0) send_byte(8'($urandom));
            random_record($urandom_range(3) == 0);
            rand_bytes += byte_count;
         end
         if ($urandom_range(2) == 0) begin
            // hold off until all outstanding responses are out
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end

      drain();
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
sv/dfrv_pkg.sv
sv/dfrv_front.sv
sv/dfrv_queue.sv
sv/dfrv_back.sv
sv/defer_record_validator.sv
tb/record_checker.sv
tb/tb.sv
